@@ hw/rtl/ple_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ple_pkg;

  localparam int unsigned CAPACITY_DEFAULT = 64;

  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;

  typedef enum logic [OPCODE_W-1:0] {
    OP_GET       = 3'd0,
    OP_ADD_FRONT = 3'd1,
    OP_ADD_BACK  = 3'd2,
    OP_INSERT    = 3'd3,
    OP_DEL_FRONT = 3'd4,
    OP_DEL_BACK  = 3'd5,
    OP_DEL_POS   = 3'd6
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_PLACE,
    S_SHIFT_DOWN,
    S_FIN
  } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/positional_list_engine.sv @@
// Ordered list of up to CAPACITY signed 32-bit values, kept in one
// synchronous memory (one write port, one registered read port).
// Input channel (in_valid/in_stall) carries one word: opcode, value, pos.
// Output channel (out_valid/out_stall) returns exactly one word per input
// word: read_value, found, status and element_count after the operation.
// One operation is in flight at a time; in_stall is high while it works.
// Path from accept to result (output free):
//   get, append, add to full list, rejected op, delete of last element: straight to S_FIN
//   insert with k cells moved up:   k S_SHIFT_UP steps, then S_PLACE, then S_FIN
//   delete with k cells moved down: k S_SHIFT_DOWN steps, then S_FIN
// Cells move one per cycle: each cycle reads one cell and
// writes its neighbor through the memory's single write port.
// The result sits in an output register; a stalled result holds there, and
// the next operation may run meanwhile, waiting only to hand off its own
// result. Reset (rst, synchronous) empties the list and drops any pending
// result; the memory needs no clearing since only cells below the count
// are ever read.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_engine #(
  parameter int unsigned CAPACITY = ple_pkg::CAPACITY_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [ple_pkg::OPCODE_W-1:0]        opcode,
  input  wire logic signed [ple_pkg::VALUE_W-1:0]  value,
  input  wire logic [ple_pkg::POS_W-1:0]           pos,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [ple_pkg::VALUE_W-1:0]       read_value,
  output logic                                     found,
  output logic [ple_pkg::STATUS_W-1:0]             status,
  output logic [ple_pkg::COUNT_W-1:0]              element_count
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = ple_pkg::POS_W;

  ple_pkg::state_t  state, state_next;
  ple_pkg::status_t res_status, res_status_next;
  logic             res_found, res_found_next;
  logic [CW-1:0]    count, count_next;
  logic [AW-1:0]    ptr, ptr_next;
  logic [AW-1:0]    idx, idx_next;
  logic signed [ple_pkg::VALUE_W-1:0] val_reg, val_next;

  logic signed [ple_pkg::VALUE_W-1:0] mem [CAPACITY];
  logic signed [ple_pkg::VALUE_W-1:0] rd_data;
  logic                               rd_en, wr_en;
  logic [AW-1:0]                      rd_addr, wr_addr;
  logic signed [ple_pkg::VALUE_W-1:0] wr_data;

  logic          accept, out_load;
  logic [PW-1:0] count8, ins_pos, del_pos;
  logic          del_ok;

  assign accept = in_valid && (state == ple_pkg::S_IDLE);
  assign count8 = PW'(count);

  always_comb begin
    state_next      = state;
    count_next      = count;
    ptr_next        = ptr;
    idx_next        = idx;
    val_next        = val_reg;
    res_found_next  = res_found;
    res_status_next = res_status;
    rd_en           = 1'b0;
    rd_addr         = ptr;
    wr_en           = 1'b0;
    wr_addr         = ptr;
    wr_data         = rd_data;
    in_stall        = 1'b1;
    out_load        = 1'b0;
    ins_pos         = count8;
    del_pos         = '0;
    del_ok          = 1'b1;

    unique case (state)
      ple_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (accept) begin
          res_found_next  = 1'b0;
          res_status_next = ple_pkg::ST_DONE;
          val_next        = value;
          state_next      = ple_pkg::S_FIN;
          unique case (opcode) inside
            ple_pkg::OP_GET: begin
              if (pos != '0 && pos <= count8) begin
                res_found_next = 1'b1;
                rd_en          = 1'b1;
                rd_addr        = AW'(pos - PW'(1));
              end
            end
            ple_pkg::OP_ADD_FRONT, ple_pkg::OP_ADD_BACK, ple_pkg::OP_INSERT: begin
              if (opcode == ple_pkg::OP_ADD_FRONT) begin
                ins_pos = '0;
              end else if (opcode == ple_pkg::OP_INSERT && pos < count8) begin
                ins_pos = pos;
              end
              if (count == CW'(CAPACITY)) begin
                res_status_next = ple_pkg::ST_FULL;
              end else if (ins_pos == count8) begin
                // append: no cells to move
                wr_en      = 1'b1;
                wr_addr    = AW'(ins_pos);
                wr_data    = value;
                count_next = count + CW'(1);
              end else begin
                idx_next   = AW'(ins_pos);
                ptr_next   = AW'(count - CW'(1));
                rd_en      = 1'b1;
                rd_addr    = AW'(count - CW'(1));
                state_next = ple_pkg::S_SHIFT_UP;
              end
            end
            ple_pkg::OP_DEL_FRONT, ple_pkg::OP_DEL_BACK, ple_pkg::OP_DEL_POS: begin
              if (opcode == ple_pkg::OP_DEL_BACK) begin
                del_pos = count8 - PW'(1);
              end else if (opcode == ple_pkg::OP_DEL_POS) begin
                del_ok  = (pos != '0) && (pos <= count8);
                del_pos = pos - PW'(1);
              end
              if (count == '0 || !del_ok) begin
                res_status_next = ple_pkg::ST_INVALID;
              end else if (del_pos == count8 - PW'(1)) begin
                count_next = count - CW'(1);
              end else begin
                ptr_next   = AW'(del_pos + PW'(1));
                rd_en      = 1'b1;
                rd_addr    = AW'(del_pos + PW'(1));
                state_next = ple_pkg::S_SHIFT_DOWN;
              end
            end
            default: begin
              res_status_next = ple_pkg::ST_INVALID;
            end
          endcase
        end
      end

      // rd_data holds cell ptr; move it up one and fetch the one below
      ple_pkg::S_SHIFT_UP: begin
        wr_en   = 1'b1;
        wr_addr = ptr + AW'(1);
        wr_data = rd_data;
        if (ptr == idx) begin
          state_next = ple_pkg::S_PLACE;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = ptr - AW'(1);
          ptr_next = ptr - AW'(1);
        end
      end

      ple_pkg::S_PLACE: begin
        wr_en      = 1'b1;
        wr_addr    = idx;
        wr_data    = val_reg;
        count_next = count + CW'(1);
        state_next = ple_pkg::S_FIN;
      end

      // rd_data holds cell ptr; move it down one and fetch the next
      ple_pkg::S_SHIFT_DOWN: begin
        wr_en   = 1'b1;
        wr_addr = ptr - AW'(1);
        wr_data = rd_data;
        if (CW'(ptr) == count - CW'(1)) begin
          count_next = count - CW'(1);
          state_next = ple_pkg::S_FIN;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = ptr + AW'(1);
          ptr_next = ptr + AW'(1);
        end
      end

      ple_pkg::S_FIN: begin
        out_load = !out_valid || !out_stall;
        if (out_load) begin
          state_next = ple_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = ple_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ple_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    idx        <= idx_next;
    val_reg    <= val_next;
    res_found  <= res_found_next;
    res_status <= res_status_next;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      read_value    <= res_found ? rd_data : '0;
      found         <= res_found;
      status        <= res_status;
      element_count <= ple_pkg::COUNT_W'(count);
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ple_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ple_checker #(
  parameter int unsigned CAPACITY = ple_pkg::CAPACITY_DEFAULT
) (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               in_valid,
  input wire logic                               in_stall,
  input wire logic [ple_pkg::OPCODE_W-1:0]       opcode,
  input wire logic signed [ple_pkg::VALUE_W-1:0] value,
  input wire logic [ple_pkg::POS_W-1:0]          pos,
  input wire logic                               out_valid,
  input wire logic                               out_stall,
  input wire logic signed [ple_pkg::VALUE_W-1:0] read_value,
  input wire logic                               found,
  input wire logic [ple_pkg::STATUS_W-1:0]       status,
  input wire logic [ple_pkg::COUNT_W-1:0]        element_count
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_value) && $stable(found)
      && $stable(status) && $stable(element_count))
    else $error("stalled result word changed");

  a_found_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> status == ple_pkg::ST_DONE)
    else $error("hit reported with error status");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> read_value == '0)
    else $error("read value nonzero without hit");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ple_pkg::ST_FULL |->
      element_count == ple_pkg::COUNT_W'(CAPACITY))
    else $error("full status with list not full");

  // a stalled input word holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(opcode) && $stable(value)
      && $stable(pos))
    else $error("stalled input word changed");

endmodule

bind positional_list_engine ple_checker #(.CAPACITY(CAPACITY)) u_ple_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .opcode        (opcode),
  .value         (value),
  .pos           (pos),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .read_value    (read_value),
  .found         (found),
  .status        (status),
  .element_count (element_count)
);

`default_nettype wire

@@ tb/tb_positional_list_engine.sv @@
`timescale 1ns / 1ps

module tb_positional_list_engine;

  localparam int unsigned CAP = ple_pkg::CAPACITY_DEFAULT;
  localparam logic [ple_pkg::OPCODE_W-1:0] OP_UNUSED = 3'd7;
  localparam logic signed [ple_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [ple_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 100;
  localparam int RANDOM_WORDS = 930;
  localparam int PHASE_WORDS  = 120;
  localparam int N_ROWS       = 25;

  typedef struct {
    logic signed [ple_pkg::VALUE_W-1:0] read_value;
    logic                               found;
    ple_pkg::status_t                   status;
    logic [ple_pkg::COUNT_W-1:0]        count;
  } list_result_t;

  typedef struct {
    logic [ple_pkg::OPCODE_W-1:0]       op;
    logic signed [ple_pkg::VALUE_W-1:0] val;
    logic [ple_pkg::POS_W-1:0]          p;
    bit                                 typed;
    list_result_t                       want;
  } stim_row_t;

  typedef enum {BIAS_GROW, BIAS_MIX, BIAS_SHRINK} bias_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [ple_pkg::OPCODE_W-1:0]       opcode = '0;
  logic signed [ple_pkg::VALUE_W-1:0] value = '0;
  logic [ple_pkg::POS_W-1:0]          pos = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic signed [ple_pkg::VALUE_W-1:0] read_value;
  logic                               found;
  logic [ple_pkg::STATUS_W-1:0]       status;
  logic [ple_pkg::COUNT_W-1:0]        element_count;

  // shadow copy of the list and the results still owed by the block
  logic signed [ple_pkg::VALUE_W-1:0] shadow_list[$];
  list_result_t                       pending_results[$];
  list_result_t                       want;
  list_result_t                       no_result;

  bit calm = 1'b0;
  int mismatches   = 0;
  int words_sent   = 0;
  int results_seen = 0;
  int full_drops   = 0;
  int rejects      = 0;
  int peak_depth   = 0;
  int idle_cycles  = 0;
  int stall_left   = 0;
  int hold;

  // typed expectations only where they follow at a glance
  stim_row_t directed_rows [N_ROWS] = '{
    '{ple_pkg::OP_GET,       '0,      8'd0,   1'b1, '{'0, 1'b0, ple_pkg::ST_DONE, 7'd0}},
    '{ple_pkg::OP_DEL_FRONT, '0,      8'd0,   1'b1, '{'0, 1'b0, ple_pkg::ST_INVALID, 7'd0}},
    '{ple_pkg::OP_DEL_BACK,  '0,      8'd0,   1'b1, '{'0, 1'b0, ple_pkg::ST_INVALID, 7'd0}},
    '{ple_pkg::OP_DEL_POS,   '0,      8'd1,   1'b1, '{'0, 1'b0, ple_pkg::ST_INVALID, 7'd0}},
    '{ple_pkg::OP_INSERT,    VAL_MAX, 8'd5,   1'b1, '{'0, 1'b0, ple_pkg::ST_DONE, 7'd1}},
    '{ple_pkg::OP_ADD_FRONT, VAL_MIN, 8'd0,   1'b1, '{'0, 1'b0, ple_pkg::ST_DONE, 7'd2}},
    '{ple_pkg::OP_ADD_BACK,  -32'sd1, 8'd0,   1'b1, '{'0, 1'b0, ple_pkg::ST_DONE, 7'd3}},
    '{ple_pkg::OP_GET,       '0,      8'd1,   1'b1, '{VAL_MIN, 1'b1, ple_pkg::ST_DONE, 7'd3}},
    '{ple_pkg::OP_GET,       '0,      8'd3,   1'b1, '{-32'sd1, 1'b1, ple_pkg::ST_DONE, 7'd3}},
    '{ple_pkg::OP_GET,       '0,      8'd0,   1'b1, '{'0, 1'b0, ple_pkg::ST_DONE, 7'd3}},
    '{ple_pkg::OP_GET,       '0,      8'd255, 1'b1, '{'0, 1'b0, ple_pkg::ST_DONE, 7'd3}},
    '{ple_pkg::OP_INSERT,    32'sd5,  8'd0,   1'b0, '{'0, 1'b0, ple_pkg::ST_DONE, 7'd0}},
    '{ple_pkg::OP_INSERT,    32'sd6,  8'd2,   1'b0, '{'0, 1'b0, ple_pkg::ST_DONE, 7'd0}},
    '{ple_pkg::OP_INSERT,    32'sd7,  8'd200, 1'b0, '{'0, 1'b0, ple_pkg::ST_DONE, 7'd0}},
    '{ple_pkg::OP_DEL_POS,   '0,      8'd0,   1'b1, '{'0, 1'b0, ple_pkg::ST_INVALID, 7'd6}},
    '{ple_pkg::OP_DEL_POS,   '0,      8'd255, 1'b1, '{'0, 1'b0, ple_pkg::ST_INVALID, 7'd6}},
    '{ple_pkg::OP_DEL_POS,   '0,      8'd7,   1'b1, '{'0, 1'b0, ple_pkg::ST_INVALID, 7'd6}},
    '{ple_pkg::OP_DEL_POS,   '0,      8'd3,   1'b0, '{'0, 1'b0, ple_pkg::ST_DONE, 7'd0}},
    '{OP_UNUSED, 32'sh5555_AAAA, 8'hAA, 1'b1, '{'0, 1'b0, ple_pkg::ST_INVALID, 7'd5}},
    '{ple_pkg::OP_GET,       '0,      8'd3,   1'b0, '{'0, 1'b0, ple_pkg::ST_DONE, 7'd0}},
    '{ple_pkg::OP_DEL_BACK,  '0,      8'd0,   1'b0, '{'0, 1'b0, ple_pkg::ST_DONE, 7'd0}},
    '{ple_pkg::OP_DEL_FRONT, '0,      8'd0,   1'b0, '{'0, 1'b0, ple_pkg::ST_DONE, 7'd0}},
    '{ple_pkg::OP_GET,       '0,      8'd1,   1'b0, '{'0, 1'b0, ple_pkg::ST_DONE, 7'd0}},
    '{ple_pkg::OP_INSERT,    32'sd8,  8'd1,   1'b0, '{'0, 1'b0, ple_pkg::ST_DONE, 7'd0}},
    '{ple_pkg::OP_GET,       '0,      8'd2,   1'b0, '{'0, 1'b0, ple_pkg::ST_DONE, 7'd0}}
  };

  positional_list_engine #(
    .CAPACITY(CAP)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .value(value),
    .pos(pos),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .read_value(read_value),
    .found(found),
    .status(status),
    .element_count(element_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic list_result_t list_apply(
    input logic [ple_pkg::OPCODE_W-1:0]       op,
    input logic signed [ple_pkg::VALUE_W-1:0] val,
    input logic [ple_pkg::POS_W-1:0]          p
  );
    list_result_t r;
    int depth;
    r.read_value = '0;
    r.found = 1'b0;
    r.status = ple_pkg::ST_DONE;
    depth = shadow_list.size();
    case (op)
      ple_pkg::OP_GET: begin
        if (p >= 1 && p <= depth) begin
          r.read_value = shadow_list[p - 1];
          r.found = 1'b1;
        end
      end
      ple_pkg::OP_ADD_FRONT, ple_pkg::OP_ADD_BACK, ple_pkg::OP_INSERT: begin
        if (depth >= CAP) r.status = ple_pkg::ST_FULL;
        else if (op == ple_pkg::OP_ADD_FRONT) shadow_list.push_front(val);
        else if (op == ple_pkg::OP_ADD_BACK) shadow_list.push_back(val);
        else shadow_list.insert((p < depth) ? int'(p) : depth, val);
      end
      ple_pkg::OP_DEL_FRONT, ple_pkg::OP_DEL_BACK, ple_pkg::OP_DEL_POS: begin
        if (depth == 0) r.status = ple_pkg::ST_INVALID;
        else if (op == ple_pkg::OP_DEL_FRONT) void'(shadow_list.pop_front());
        else if (op == ple_pkg::OP_DEL_BACK) void'(shadow_list.pop_back());
        else if (p == 0 || p > depth) r.status = ple_pkg::ST_INVALID;
        else shadow_list.delete(p - 1);
      end
      default: r.status = ple_pkg::ST_INVALID;
    endcase
    if (shadow_list.size() > peak_depth) peak_depth = shadow_list.size();
    r.count = ple_pkg::COUNT_W'(shadow_list.size());
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] result %0d: %s", $time, results_seen, what);
    mismatches++;
  endtask

  task automatic send_word(input logic [ple_pkg::OPCODE_W-1:0]       op,
                           input logic signed [ple_pkg::VALUE_W-1:0] val,
                           input logic [ple_pkg::POS_W-1:0]          p,
                           input bit                                 typed,
                           input list_result_t                       typed_result);
    list_result_t predicted;
    int gap;
    opcode   <= op;
    value    <= val;
    pos      <= p;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = list_apply(op, val, p);
    pending_results.push_back(typed ? typed_result : predicted);
    words_sent++;
    gap = calm ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    bias_t bias;
    int add_cut, get_cut, del_cut;
    int r, depth;
    logic [ple_pkg::OPCODE_W-1:0] op;
    logic signed [ple_pkg::VALUE_W-1:0] val;
    logic [ple_pkg::POS_W-1:0] p;
    bias = BIAS_GROW;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_word(directed_rows[i].op, directed_rows[i].val, directed_rows[i].p,
                directed_rows[i].typed, directed_rows[i].want);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % PHASE_WORDS == 0) begin
        // hold off until every owed result is back
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
        bias = bias_t'((n / PHASE_WORDS) % 3);
        calm = ((n / PHASE_WORDS) % 4 == 3);
      end
      case (bias)
        BIAS_GROW:   begin add_cut = 75; get_cut = 90; del_cut = 98; end
        BIAS_MIX:    begin add_cut = 40; get_cut = 70; del_cut = 98; end
        default:     begin add_cut = 15; get_cut = 30; del_cut = 98; end
      endcase
      r = $urandom_range(0, 99);
      if (r < add_cut)
        op = ple_pkg::OPCODE_W'($urandom_range(int'(ple_pkg::OP_ADD_FRONT),
                                               int'(ple_pkg::OP_INSERT)));
      else if (r < get_cut) op = ple_pkg::OP_GET;
      else if (r < del_cut)
        op = ple_pkg::OPCODE_W'($urandom_range(int'(ple_pkg::OP_DEL_FRONT),
                                               int'(ple_pkg::OP_DEL_POS)));
      else op = OP_UNUSED;

      depth = shadow_list.size();
      r = $urandom_range(0, 9);
      if (r < 7) p = ple_pkg::POS_W'($urandom_range(0, depth + 1));
      else if (r < 9) p = ple_pkg::POS_W'($urandom_range(0, 255));
      else p = $urandom_range(0, 1) ? '1 : '0;

      r = $urandom_range(0, 9);
      if (r < 8) val = $urandom;
      else begin
        case ($urandom_range(0, 3))
          0: val = VAL_MIN;
          1: val = VAL_MAX;
          2: val = -32'sd1;
          default: val = '0;
        endcase
      end
      send_word(op, val, p, 1'b0, no_result);
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d words and %0d results, list depth up to %0d of %0d",
             words_sent, results_seen, peak_depth, CAP);
    $display("adds refused on a full list: %0d, rejected ops: %0d", full_drops, rejects);
    if (mismatches == 0) begin
      $display("positional_list_engine: match");
    end else begin
      $display("positional_list_engine: mismatch");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      hold = calm ? 0 : idle_len();
      out_stall  <= (hold != 0);
      stall_left <= (hold != 0) ? hold - 1 : 0;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result word with nothing pending");
        end else begin
          want = pending_results.pop_front();
          if (read_value !== want.read_value)
            report_mismatch($sformatf("read_value %0d, predicted %0d",
                                      read_value, want.read_value));
          if (found !== want.found)
            report_mismatch($sformatf("found %b, predicted %b", found, want.found));
          if (status !== want.status)
            report_mismatch($sformatf("status %0d, predicted %s",
                                      status, want.status.name()));
          if (element_count !== want.count)
            report_mismatch($sformatf("element_count %0d, predicted %0d",
                                      element_count, want.count));
          if (status == ple_pkg::ST_FULL) full_drops++;
          if (status == ple_pkg::ST_INVALID) rejects++;
        end
        results_seen++;
      end
      // watchdog: no word moving on either side for too long
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
        $display("positional_list_engine: mismatch");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
